FILE: hw/rtl/bwbp_pkg.sv
// bwbp_pkg: shared types and constants for the butterworth band-pass cascade
// used by bwbp_ctrl, bwbp_dp and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bwbp_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int STATE_W  = 48;
    localparam int LEN_W    = 25;
    localparam int POS_W    = 24;
    localparam int SEL_W    = 3;

    // datapath widths
    localparam int OPND_W = 28;                 // multiplier operand, signed
    localparam int PROD_W = COEF_W + OPND_W;    // 60
    localparam int TERM_W = PROD_W + 24;        // 84, full product of coef and 51-bit value
    localparam int ACC_W  = 56;                 // recursive sum before saturation
    localparam int GIN_W  = 51;                 // w0 - 2*w2 + w4
    localparam int FRAC   = 28;                 // coefficient fraction bits

    // coefficient kinds
    localparam logic [SEL_W-1:0] KIND_GAIN = 3'd0;
    localparam logic [SEL_W-1:0] KIND_D1   = 3'd1;
    localparam logic [SEL_W-1:0] KIND_D2   = 3'd2;
    localparam logic [SEL_W-1:0] KIND_D3   = 3'd3;
    localparam logic [SEL_W-1:0] KIND_D4   = 3'd4;
    localparam int               NUM_KINDS = 5;

    // configuration register indexes
    localparam logic CFG_REVERSE = 1'b0;
    localparam logic CFG_LENGTH  = 1'b1;

    // input actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    // multiplier operand source
    typedef enum logic [2:0] {
        SRC_W1  = 3'd0,
        SRC_W2  = 3'd1,
        SRC_W3  = 3'd2,
        SRC_W4  = 3'd3,
        SRC_GIN = 3'd4
    } t_src;

    // controller to datapath commands
    typedef struct packed {
        logic             take_sample;
        logic             coef_wr;
        logic             acc_load;
        logic             mul_hi;
        logic             mul_lo;
        t_src             src;
        logic [SEL_W-1:0] kind;
        logic             comb;
        logic             acc_add;
        logic             w0_load;
        logic             gin_load;
        logic             sec_done;
        logic             finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/bwbp_ctrl.sv
// bwbp_ctrl: sequencer for the shared multiply-accumulate datapath
// depends on bwbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bwbp_ctrl import bwbp_pkg::*; #(
    parameter int SECTIONS = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    input  wire logic    i_s_action,
    input  wire logic    i_m_ready,
    output logic         o_s_ready,
    output logic         o_m_valid,
    output t_dp_cmd      o_cmd
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // per-section schedule
    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] STEP_FIRST_CMB = 4'd2;
    localparam logic [3:0] STEP_LAST_MUL  = 4'd7;
    localparam logic [3:0] STEP_LAST_CMB  = 4'd8;
    localparam logic [3:0] STEP_FIRST_ACC = 4'd3;
    localparam logic [3:0] STEP_LAST_ACC  = 4'd9;
    localparam logic [3:0] STEP_W0        = 4'd10;
    localparam logic [3:0] STEP_GIN       = 4'd11;
    localparam logic [3:0] STEP_GAIN_HI   = 4'd12;
    localparam logic [3:0] STEP_GAIN_LO   = 4'd13;
    localparam logic [3:0] STEP_GAIN_CMB  = 4'd14;
    localparam logic [3:0] STEP_SEC_END   = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [3:0]       r_step, n_step;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic             r_m_valid, n_m_valid;
    logic             w_accept, w_out_free, w_sec_last, w_run;

    assign w_accept   = i_s_valid && o_s_ready;
    assign w_out_free = !r_m_valid || i_m_ready;
    assign w_sec_last = (r_sec == SEC_W'(SECTIONS - 1));
    assign w_run      = (r_state == ST_RUN);
    assign o_s_ready  = (r_state == ST_IDLE);
    assign o_m_valid  = r_m_valid;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_sec     = r_sec;
        n_m_valid = r_m_valid && !i_m_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_action == ACT_SAMPLE)) begin
                    n_state = ST_RUN;
                    n_step  = STEP_FIRST;
                    n_sec   = '0;
                end
            end
            ST_RUN: begin
                n_step = r_step + 4'd1;
                if (r_step == STEP_SEC_END) begin
                    if (w_sec_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_sec = r_sec + SEC_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state   = ST_IDLE;
                    n_m_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command decode from the schedule step
    always_comb begin
        o_cmd             = '0;
        o_cmd.src         = SRC_W1;
        o_cmd.take_sample = w_accept && (i_s_action == ACT_SAMPLE);
        o_cmd.coef_wr     = w_accept && (i_s_action == ACT_COEF);
        o_cmd.finish      = (r_state == ST_DONE) && w_out_free;
        if (w_run) begin
            o_cmd.acc_load = (r_step == STEP_FIRST);
            if (r_step <= STEP_LAST_MUL) begin
                // taps d1..d4, each as a high then a low half product
                o_cmd.mul_hi = !r_step[0];
                o_cmd.mul_lo = r_step[0];
                o_cmd.src    = t_src'({1'b0, r_step[2:1]});
                o_cmd.kind   = {1'b0, r_step[2:1]} + KIND_D1;
            end else if ((r_step == STEP_GAIN_HI) || (r_step == STEP_GAIN_LO)) begin
                o_cmd.mul_hi = (r_step == STEP_GAIN_HI);
                o_cmd.mul_lo = (r_step == STEP_GAIN_LO);
                o_cmd.src    = SRC_GIN;
                o_cmd.kind   = KIND_GAIN;
            end
            o_cmd.comb     = (!r_step[0] && (r_step >= STEP_FIRST_CMB)
                              && (r_step <= STEP_LAST_CMB)) || (r_step == STEP_GAIN_CMB);
            o_cmd.acc_add  = r_step[0] && (r_step >= STEP_FIRST_ACC)
                             && (r_step <= STEP_LAST_ACC);
            o_cmd.w0_load  = (r_step == STEP_W0);
            o_cmd.gin_load = (r_step == STEP_GIN);
            o_cmd.sec_done = (r_step == STEP_SEC_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_sec     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_sec     <= n_sec;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bwbp_dp.sv
// bwbp_dp: coefficient and delay storage, shared 32x28 multiplier, accumulator,
// output rounding and record position; depends on bwbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bwbp_dp import bwbp_pkg::*; #(
    parameter int SECTIONS = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [SEL_W-1:0]           i_coef_section,
    input  wire logic [SEL_W-1:0]           i_coef_kind,
    input  wire logic signed [COEF_W-1:0]   i_coef_value,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_addr,
    input  wire logic [LEN_W-1:0]           i_cfg_wdata,
    output logic signed [SAMPLE_W-1:0]      o_filtered,
    output logic [POS_W-1:0]                o_position,
    output logic                            o_eor,
    output logic                            o_sat
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // row 0 always holds the section being worked on; rows rotate per section
    logic signed [COEF_W-1:0]  r_coef [SECTIONS][NUM_KINDS];
    logic signed [STATE_W-1:0] r_dl   [SECTIONS][4];

    logic                      r_rev;
    logic [LEN_W-1:0]          r_len;
    logic [POS_W-1:0]          r_cnt;

    logic signed [STATE_W-1:0] r_x;
    logic signed [STATE_W-1:0] r_w0;
    logic signed [GIN_W-1:0]   r_gin;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_hi;
    logic signed [TERM_W-1:0]  r_term;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [SAMPLE_W-1:0] r_filtered;
    logic [POS_W-1:0]           r_position;
    logic                       r_eor;
    logic                       r_sat;

    logic signed [GIN_W-1:0]   w_v;
    logic signed [OPND_W-1:0]  w_b;
    logic signed [COEF_W-1:0]  w_c;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_coef_ok;
    logic [POS_W-1:0]          w_lenm1, w_c_cnt, w_pos;
    logic                      w_eor;
    logic signed [STATE_W:0]   w_xr;
    logic signed [STATE_W-8:0] w_y;
    logic                      w_y_fits;
    logic signed [SAMPLE_W-1:0] w_y_sat;

    function automatic logic signed [STATE_W-1:0] sat48(input logic signed [ACC_W-1:0] a);
        logic hi_same;
        hi_same = (a[ACC_W-1:STATE_W-1] == '0) || (a[ACC_W-1:STATE_W-1] == '1);
        if (hi_same) begin
            sat48 = a[STATE_W-1:0];
        end else if (a[ACC_W-1]) begin
            sat48 = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            sat48 = {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

    // operand select
    always_comb begin
        unique case (i_cmd.src)
            SRC_W1:  w_v = GIN_W'(r_dl[0][0]);
            SRC_W2:  w_v = GIN_W'(r_dl[0][1]);
            SRC_W3:  w_v = GIN_W'(r_dl[0][2]);
            SRC_W4:  w_v = GIN_W'(r_dl[0][3]);
            SRC_GIN: w_v = r_gin;
            default: w_v = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.kind)
            KIND_GAIN: w_c = r_coef[0][0];
            KIND_D1:   w_c = r_coef[0][1];
            KIND_D2:   w_c = r_coef[0][2];
            KIND_D3:   w_c = r_coef[0][3];
            KIND_D4:   w_c = r_coef[0][4];
            default:   w_c = '0;
        endcase
    end

    // high half signed, low 24 bits unsigned
    assign w_b    = i_cmd.mul_hi ? {w_v[GIN_W-1], w_v[GIN_W-1:24]} : {4'b0, w_v[23:0]};
    assign w_prod = w_c * w_b;

    assign w_coef_ok = ({1'b0, i_coef_section} < 4'(SECTIONS)) && (i_coef_kind <= KIND_D4);

    // record position
    always_comb begin
        if (r_len[LEN_W-1]) begin
            w_lenm1 = '1;
        end else if (r_len == '0) begin
            w_lenm1 = '0;
        end else begin
            w_lenm1 = r_len[POS_W-1:0] - POS_W'(1);
        end
        w_c_cnt = (r_cnt > w_lenm1) ? '0 : r_cnt;
        w_eor   = (w_c_cnt == w_lenm1);
        w_pos   = r_rev ? (w_lenm1 - w_c_cnt) : w_c_cnt;
    end

    // round half up and clip to the sample range
    assign w_xr     = {r_x[STATE_W-1], r_x} + (STATE_W+1)'(128);
    assign w_y      = w_xr[STATE_W:8];
    assign w_y_fits = (w_y[STATE_W-8:SAMPLE_W-1] == '0) || (w_y[STATE_W-8:SAMPLE_W-1] == '1);
    assign w_y_sat  = w_y_fits ? w_y[SAMPLE_W-1:0]
                    : (w_y[STATE_W-8] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}});

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= 1'b0;
            r_len <= LEN_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_REVERSE: r_rev <= i_cfg_wdata[0];
                CFG_LENGTH:  r_len <= i_cfg_wdata;
                default:     r_rev <= r_rev;
            endcase
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                for (int k = 0; k < NUM_KINDS; k++) begin
                    r_coef[s][k] <= '0;
                end
            end
        end else if (i_cmd.coef_wr && w_coef_ok) begin
            r_coef[i_coef_section[SEC_W-1:0]][i_coef_kind] <= i_coef_value;
        end else if (i_cmd.sec_done) begin
            for (int s = 0; s < SECTIONS - 1; s++) begin
                r_coef[s] <= r_coef[s+1];
            end
            r_coef[SECTIONS-1] <= r_coef[0];
        end
    end

    // delay lines and record counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                for (int k = 0; k < 4; k++) begin
                    r_dl[s][k] <= '0;
                end
            end
            r_cnt <= '0;
        end else if (i_cmd.finish) begin
            if (w_eor) begin
                for (int s = 0; s < SECTIONS; s++) begin
                    for (int k = 0; k < 4; k++) begin
                        r_dl[s][k] <= '0;
                    end
                end
                r_cnt <= '0;
            end else begin
                r_cnt <= w_c_cnt + POS_W'(1);
            end
        end else if (i_cmd.sec_done) begin
            for (int s = 0; s < SECTIONS - 1; s++) begin
                r_dl[s] <= r_dl[s+1];
            end
            r_dl[SECTIONS-1][0] <= r_w0;
            r_dl[SECTIONS-1][1] <= r_dl[0][0];
            r_dl[SECTIONS-1][2] <= r_dl[0][1];
            r_dl[SECTIONS-1][3] <= r_dl[0][2];
        end
    end

    // multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_x <= {{(STATE_W-SAMPLE_W-8){i_sample[SAMPLE_W-1]}}, i_sample, 8'b0};
        end else if (i_cmd.sec_done) begin
            r_x <= sat48(r_term[TERM_W-1:FRAC]);
        end
        if (i_cmd.mul_hi || i_cmd.mul_lo) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_lo) begin
            r_hi <= r_prod;
        end
        if (i_cmd.comb) begin
            r_term <= {r_hi, 24'b0} + TERM_W'(r_prod);
        end
        if (i_cmd.acc_load) begin
            r_acc <= ACC_W'(r_x);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_term[TERM_W-1:FRAC];
        end
        if (i_cmd.w0_load) begin
            r_w0 <= sat48(r_acc);
        end
        if (i_cmd.gin_load) begin
            r_gin <= GIN_W'(r_w0) - (GIN_W'(r_dl[0][1]) <<< 1) + GIN_W'(r_dl[0][3]);
        end
        if (i_cmd.finish) begin
            r_filtered <= w_y_sat;
            r_sat      <= !w_y_fits;
            r_position <= w_pos;
            r_eor      <= w_eor;
        end
    end

    assign o_filtered = r_filtered;
    assign o_position = r_position;
    assign o_eor      = r_eor;
    assign o_sat      = r_sat;

endmodule

`default_nettype wire

FILE: hw/rtl/butterworth_bandpass_iir_top.sv
// butterworth_bandpass_iir_top: top level of the band-pass cascade
// instantiates bwbp_ctrl and bwbp_dp, uses bwbp_pkg
`timescale 1ns / 1ps
`default_nettype none

// Streams 24-bit signed samples through SECTIONS fourth-order band-pass
// sections in cascade and returns one result beat per sample: the rounded,
// clipped output with a clip flag (tuser), its record position and an
// end-of-record mark (tlast). An input beat with tuser high writes one Q3.28
// coefficient (gain or d1..d4 of one section) and gives no result; writes to
// a section or kind out of range are dropped. A coefficient write leaves
// the input side ready. A sample is taken, then runs through each section
// in turn on a single shared 32x28 signed multiplier (every 51-bit operand
// goes through it as a high and a low half) and is rounded; no new beat is
// taken while a sample runs or while its result waits for the result
// register to be free. A finished result waits in the output register
// while the next beat is taken. After the last sample of a record all
// delay values and the position count return to zero. The configuration
// port (reverse direction, record length) is to be written by the user only
// while the block is idle; the block itself does not enforce this.

module butterworth_bandpass_iir_top import bwbp_pkg::*; #(
    parameter int SECTIONS = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample and coefficient beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [23:0] sample_value, [26:24] coef_section, [29:27] coef_kind,
    // [61:30] coef_value, [63:62] zero
    input  wire logic [63:0] s_axis_tdata,
    // [0] action: 0 sample, 1 coefficient write
    input  wire logic        s_axis_tuser,
    // result beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [23:0] filtered_sample, [47:24] position
    output logic [47:0]      m_axis_tdata,
    // end_of_record
    output logic             m_axis_tlast,
    // [0] saturated
    output logic             m_axis_tuser,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [24:0] i_cfg_wdata
);

    t_dp_cmd                    w_cmd;
    logic signed [SAMPLE_W-1:0] w_filtered;
    logic [POS_W-1:0]           w_position;

    // sequencer: handshakes and the per-section schedule
    bwbp_ctrl #(
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_s_action (s_axis_tuser),
        .i_m_ready  (m_axis_tready),
        .o_s_ready  (s_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    // storage, shared multiplier and output register
    bwbp_dp #(
        .SECTIONS (SECTIONS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_sample       (s_axis_tdata[23:0]),
        .i_coef_section (s_axis_tdata[26:24]),
        .i_coef_kind    (s_axis_tdata[29:27]),
        .i_coef_value   (s_axis_tdata[61:30]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_filtered     (w_filtered),
        .o_position     (w_position),
        .o_eor          (m_axis_tlast),
        .o_sat          (m_axis_tuser)
    );

    // pack the result beat, first field lowest
    assign m_axis_tdata = {w_position, w_filtered};

    // a sample beat keeps the input side busy for its whole run
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_SAMPLE)) |=> !s_axis_tready)
        else $error("input still ready after a sample beat");

    // a coefficient write finishes in its own beat
    a_coef_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_COEF)) |=> s_axis_tready)
        else $error("coefficient write did not return to idle");

    // a new result only comes out of a sample run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat without a finished sample run");

endmodule

`default_nettype wire
